>>> sv/dets_pkg.sv
// ----------------------------------------------------------------------------
// dets_pkg: shared types and constants for the event trigger selector
// Payload structs, opcode codes, register indexes and store geometry.
// ----------------------------------------------------------------------------
`default_nettype none
package dets_pkg;

  localparam int TANK_COUNT = 75;
  localparam int PAD_COUNT  = 64;
  localparam int PAD_BASE   = 64;
  localparam int TANK_AW    = $clog2(TANK_COUNT);
  localparam int PAD_AW     = $clog2(PAD_COUNT);
  // every sum store is built at the larger of the two depths
  localparam int ACC_DEPTH  = (TANK_COUNT > PAD_COUNT) ? TANK_COUNT : PAD_COUNT;
  localparam int ACC_AW     = $clog2(ACC_DEPTH);
  localparam int SUM_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [2:0] {
    OP_CAPTURE = 3'd0,
    OP_HELIUM  = 3'd1,
    OP_INNER   = 3'd2,
    OP_OUTER   = 3'd3,
    OP_END     = 3'd4
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HELIUM_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCINT_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_WIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_WIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LATE_WIN     = 3'd6;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         copy_number;
    logic [19:0]        hit_energy;
    logic signed [15:0] hit_time;
    logic [19:0]        primary_energy;
  } in_item_t;

  typedef struct packed {
    logic        event_selected;
    logic [19:0] primary_energy_out;
    logic [23:0] max_helium_sum;
    logic [24:0] scint_max_sum;
    logic [7:0]  counted_hits;
  } out_item_t;

  // one update headed for a sum store
  typedef struct packed {
    logic              en;
    logic [7:0]        idx;
    logic [19:0]       energy;
  } acc_req_t;

endpackage
`default_nettype wire

>>> sv/dets_ram.sv
// ----------------------------------------------------------------------------
// dets_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module dets_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/dets_accum.sv
// ----------------------------------------------------------------------------
// dets_accum: per-entry saturating accumulator over one sum RAM
// Reads in stage 1, adds and writes back in stage 2 with forwarding; keeps
// per-entry valid bits and the running maximum of the event.
// ----------------------------------------------------------------------------
`default_nettype none
module dets_accum
  import dets_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire acc_req_t          req,
  input  wire logic              clear,
  output logic [SUM_W-1:0]       max_out
);

  localparam int DEPTH = ACC_DEPTH;
  localparam int AW    = ACC_AW;

  logic [DEPTH-1:0]  valid_r, valid_nxt;
  logic [SUM_W-1:0]  max_r, max_nxt;
  logic              s2_en_r;
  logic              s2_valid_r;
  logic [AW-1:0]     s2_idx_r;
  logic [19:0]       s2_e_r;
  logic [SUM_W-1:0]  rdata;
  logic [SUM_W-1:0]  old_sum;
  logic [SUM_W:0]    raw_sum;
  logic [SUM_W-1:0]  new_sum;
  logic              fwd_hit;
  logic [AW-1:0]     req_idx;

  assign req_idx = req.idx[AW-1:0];

  dets_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (s2_en_r),
    .waddr (s2_idx_r),
    .wdata (new_sum),
    .raddr (req_idx),
    .rdata (rdata)
  );

  // forward the word being written when the next update hits the same entry
  logic              fwd_r;
  logic [SUM_W-1:0]  fwd_data_r;

  always_comb begin
    if (!s2_valid_r) begin
      old_sum = '0;
    end else if (fwd_r) begin
      old_sum = fwd_data_r;
    end else begin
      old_sum = rdata;
    end
    raw_sum = {1'b0, old_sum} + {{(SUM_W-19){1'b0}}, s2_e_r};
    new_sum = raw_sum[SUM_W] ? {SUM_W{1'b1}} : raw_sum[SUM_W-1:0];
  end

  assign fwd_hit = s2_en_r && req.en && (s2_idx_r == req_idx);

  // valid bits and running maximum
  always_comb begin
    valid_nxt = valid_r;
    max_nxt   = max_r;
    if (s2_en_r) begin
      valid_nxt[s2_idx_r] = 1'b1;
      if (new_sum > max_r) begin
        max_nxt = new_sum;
      end
    end
    if (clear) begin
      valid_nxt = '0;
      max_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      max_r   <= '0;
      s2_en_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      max_r   <= max_nxt;
      s2_en_r <= req.en;
    end
  end

  // stage 2 payload; valid lookup sees this cycle's write too
  always_ff @(posedge clk) begin
    s2_idx_r   <= req_idx;
    s2_e_r     <= req.energy;
    s2_valid_r <= valid_nxt[req_idx];
    fwd_r      <= fwd_hit;
    fwd_data_r <= new_sum;
  end

  assign max_out = max_r;

endmodule
`default_nettype wire

>>> sv/detector_event_trigger_select.sv
// ----------------------------------------------------------------------------
// detector_event_trigger_select: per-event trigger selection
// ----------------------------------------------------------------------------
// Takes one hit record per cycle, back to back. Helium tank and inner/outer
// pad sums live in three RAMs updated by a two-stage read-add-write with
// forwarding, so repeated hits on one entry still run at one per cycle. An
// end-of-event item is decided in the cycle after it is accepted, once the
// last pending update has landed, and its result reaches out_valid through
// a one-deep output register with a skid slot. Input stall rises while the
// skid slot holds a result, and for an end-of-event item also while a
// result is being posted into a full, stalled output register.
// ----------------------------------------------------------------------------
`default_nettype none
module detector_event_trigger_select
  import dets_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic        capture_mode_r;
  logic [23:0] helium_thr_r, scint_thr_r;
  logic [7:0]  hit_limit_r;
  logic [14:0] outer_win_r, inner_win_r, late_win_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capture_mode_r <= 1'b0;
      helium_thr_r   <= 24'd20000;
      scint_thr_r    <= 24'd6000;
      hit_limit_r    <= 8'd2;
      outer_win_r    <= 15'd32;
      inner_win_r    <= 15'd112;
      late_win_r     <= 15'd1600;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAPTURE_MODE: capture_mode_r <= cfg_wdata[0];
        REG_HELIUM_THR:   helium_thr_r   <= cfg_wdata[23:0];
        REG_SCINT_THR:    scint_thr_r    <= cfg_wdata[23:0];
        REG_HIT_LIMIT:    hit_limit_r    <= cfg_wdata[7:0];
        REG_OUTER_WIN:    outer_win_r    <= cfg_wdata[14:0];
        REG_INNER_WIN:    inner_win_r    <= cfg_wdata[14:0];
        REG_LATE_WIN:     late_win_r     <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // ---------------- decode stage ----------------
  logic               acc_in;
  logic               capture_seen_r;
  logic signed [15:0] capture_cut_r;
  logic [7:0]         hit_cnt_r;
  logic               ev_end;
  logic signed [16:0] t, win, late, cut;
  logic               pad_in_range;
  logic [7:0]         pad_idx;
  acc_req_t           tank_req, inner_req, outer_req;
  logic               count_now;

  // end items wait in a small drain slot
  logic        pend_r;
  logic [19:0] pend_pe_r;
  logic        pend_sel_r;

  assign acc_in = in_valid && !in_stall;
  assign ev_end = acc_in && (in_data.opcode == OP_END);

  always_comb begin
    t    = {in_data.hit_time[15], in_data.hit_time};
    late = {2'b00, late_win_r};
    win  = (in_data.opcode == OP_INNER) ? {2'b00, inner_win_r} : {2'b00, outer_win_r};
    cut  = capture_mode_r ? {capture_cut_r[15], capture_cut_r} : late;
    pad_in_range = (in_data.copy_number >= 8'(PAD_BASE))
                && ({1'b0, in_data.copy_number} - 9'(PAD_BASE) < 9'(PAD_COUNT));
    pad_idx = in_data.copy_number - 8'(PAD_BASE);

    tank_req        = '0;
    inner_req       = '0;
    outer_req       = '0;
    tank_req.idx    = in_data.copy_number;
    tank_req.energy = in_data.hit_energy;
    inner_req.idx   = pad_idx;
    inner_req.energy = in_data.hit_energy;
    outer_req.idx   = pad_idx;
    outer_req.energy = in_data.hit_energy;
    count_now = 1'b0;

    if (acc_in && in_data.hit_energy != '0) begin
      case (in_data.opcode)
        OP_HELIUM: begin
          if (in_data.copy_number < 8'(TANK_COUNT)
              && (!capture_mode_r || capture_seen_r) && t < cut) begin
            tank_req.en = 1'b1;
          end
        end
        OP_INNER, OP_OUTER: begin
          if (t < win) begin
            if (pad_in_range) begin
              count_now = 1'b1;
              if (in_data.opcode == OP_INNER) begin
                inner_req.en = 1'b1;
              end else begin
                outer_req.en = 1'b1;
              end
            end
          end else if (t > win && t < late) begin
            count_now = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // event bookkeeping in the decode stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capture_seen_r <= 1'b0;
      capture_cut_r  <= '0;
      hit_cnt_r      <= '0;
    end else if (ev_end) begin
      capture_seen_r <= 1'b0;
      capture_cut_r  <= '0;
      hit_cnt_r      <= '0;
    end else begin
      if (acc_in && in_data.opcode == OP_CAPTURE && !capture_seen_r
          && in_data.hit_time > 16'sd0) begin
        capture_seen_r <= 1'b1;
        capture_cut_r  <= in_data.hit_time;
      end
      if (count_now && hit_cnt_r != 8'hFF) begin
        hit_cnt_r <= hit_cnt_r + 8'd1;
      end
    end
  end

  // ---------------- sum stores ----------------
  logic [SUM_W-1:0] tank_max, inner_max, outer_max;
  logic             drain_clear;

  dets_accum u_tank (
    .clk(clk), .rst_n(rst_n), .req(tank_req), .clear(drain_clear), .max_out(tank_max));
  dets_accum u_inner (
    .clk(clk), .rst_n(rst_n), .req(inner_req), .clear(drain_clear), .max_out(inner_max));
  dets_accum u_outer (
    .clk(clk), .rst_n(rst_n), .req(outer_req), .clear(drain_clear), .max_out(outer_max));

  // ---------------- end-of-event drain ----------------
  // snapshot counter and capture status at the end item, finish next cycle
  logic [7:0]  pend_hits_r;
  logic        pend_ok_r;
  logic        fire;
  out_item_t   res;
  logic [24:0] scint;

  assign fire = pend_r;
  assign drain_clear = fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (ev_end) begin
      pend_r <= 1'b1;
    end else if (fire) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_end) begin
      pend_pe_r   <= in_data.primary_energy;
      pend_hits_r <= hit_cnt_r;
      pend_ok_r   <= !capture_mode_r || capture_seen_r;
      pend_sel_r  <= (hit_cnt_r <= hit_limit_r);
    end
  end

  always_comb begin
    scint = {1'b0, inner_max} + {1'b0, outer_max};
    res.event_selected     = pend_ok_r && pend_sel_r && (tank_max > helium_thr_r)
                          && (scint > {1'b0, scint_thr_r});
    res.primary_energy_out = pend_pe_r;
    res.max_helium_sum     = tank_max;
    res.scint_max_sum      = scint;
    res.counted_hits       = pend_hits_r;
  end

  // ---------------- output register with skid slot ----------------
  logic      ov_r, sk_r;
  out_item_t od_r, sd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sk_r <= 1'b0;
    end else begin
      if (!ov_r || !out_stall) begin
        ov_r <= sk_r || fire;
        sk_r <= sk_r && fire;
      end else if (fire) begin
        sk_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ov_r || !out_stall) begin
      od_r <= sk_r ? sd_r : res;
      if (sk_r && fire) begin
        sd_r <= res;
      end
    end else if (fire) begin
      sd_r <= res;
    end
  end

  // hold all input while the skid slot is taken, and a new end item while it is about to be
  assign in_stall  = sk_r || (pend_r && ov_r && out_stall && in_data.opcode == OP_END);
  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule
`default_nettype wire

>>> sv/dets_checker.sv
// ----------------------------------------------------------------------------
// dets_sva: port-level assertions for the trigger selector
// Watches handshake behavior and result consistency at the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module dets_sva
  import dets_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a selected event must carry nonzero sums
  a_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_selected |->
      out_data.max_helium_sum != '0 && out_data.scint_max_sum != '0)
    else $error("selected event with empty sums");

  // no result appears out of reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");

  // input stall is always resolved while a transaction is offered
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_stall))
    else $error("unknown input stall");

endmodule

bind detector_event_trigger_select dets_sva u_dets_sva (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
`default_nettype wire
